[hdl/pcal_pkg.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator package
// Shared types, register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package pcal_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PITCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_TOL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TOL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_TGT  = 3'd5;

  // Register values after reset.
  localparam logic [15:0] RST_MIN_PITCH  = 16'd800;
  localparam logic [15:0] RST_MAX_PITCH  = 16'd32000;
  localparam logic [31:0] RST_VAR_TOL    = 32'd4096;
  localparam logic [7:0]  RST_MISS_LIMIT = 8'd10;
  localparam logic [15:0] RST_CENTER_TOL = 16'd320;
  localparam logic [15:0] RST_LAUNCH_TGT = 16'd0;

  // Calibration phases.
  localparam logic [1:0] PH_HIGH      = 2'd0;
  localparam logic [1:0] PH_LOW       = 2'd1;
  localparam logic [1:0] PH_CENTER    = 2'd2;
  localparam logic [1:0] PH_COUNTDOWN = 2'd3;

  // Note capture requests passed to the output stages.
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_HIGH = 2'd1;
  localparam logic [1:0] CAP_LOW  = 2'd2;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] min_pitch;
    logic [15:0] max_pitch;
    logic [31:0] var_tol;
    logic [7:0]  miss_limit;
    logic [15:0] center_tol;
    logic [15:0] launch_target;
  } cfg_t;

  // One classified frame: masked pitch and the result of the range gate.
  typedef struct packed {
    logic [15:0] pitch;
    logic        in_range;
  } frame_t;

  // Per-frame control handed from the back to the output stages.
  typedef struct packed {
    logic [1:0] phase;
    logic       found;
    logic [1:0] cap;
  } res_ctl_t;

endpackage

[hdl/pcal_ifs.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator channels
// Valid/ready interfaces for frames, results and configuration writes.
// ----------------------------------------------------------------------------

// Input frame channel.
interface pcal_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pitch;

  modport source (output valid, output pitch, input ready);
  modport sink   (input valid, input pitch, output ready);
endinterface

// Result channel.
interface pcal_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic        found;
  logic [15:0] found_pitch;
  logic [15:0] high_pitch;
  logic [15:0] low_pitch;
  logic [15:0] center_pitch;

  modport source (output valid, output phase, output found, output found_pitch,
                  output high_pitch, output low_pitch, output center_pitch,
                  input ready);
  modport sink   (input valid, input phase, input found, input found_pitch,
                  input high_pitch, input low_pitch, input center_pitch,
                  output ready);
endinterface

// Configuration write channel.
interface pcal_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcal_pkg::CFG_IDX_W-1:0]  index;
  logic [pcal_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/pitch_stability_calibrator.sv]
// Throughput: one frame per cycle while the result channel does not stall; the window
// update is combinational around one multiplier, and the window memory read is registered
// at the next pointer.
// Reset: synchronous, active low; clears the window state, the phase, the notes and
// all valid flags, and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// Pitch stability calibrator
// Detects stable pitch over a sliding window and walks the high, low and
// centre calibration phases.
// ----------------------------------------------------------------------------
module pitch_stability_calibrator #(
  parameter int WINDOW_LENGTH = 16,
  parameter int PITCH_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pcal_in_if.sink     in_ch,
  pcal_cfg_if.sink    cfg_ch,
  pcal_out_if.source  out_ch
);
  import pcal_pkg::*;

  localparam int PW   = (PITCH_BITS < 16) ? PITCH_BITS : 16;
  localparam int LOGN = $clog2(WINDOW_LENGTH);

  cfg_t               cfg;
  frame_t             frame;
  frame_t             head;
  res_ctl_t           res_ctl;
  logic               push;
  logic               q_full;
  logic               head_valid;
  logic               pop;
  logic               res_valid;
  logic               res_ready;
  logic [PW+LOGN:0]   res_sum;

  // Front: configuration and range gate.
  pcal_front #(
    .PITCH_W (PW)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .push   (push),
    .frame  (frame),
    .cfg    (cfg)
  );

  // Queue between front and back.
  pcal_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_data    (frame),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: sliding window and phase control.
  pcal_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .PITCH_W       (PW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_ctl    (res_ctl),
    .res_sum    (res_sum)
  );

  // Output stages: mean, notes and result register.
  pcal_post #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .PITCH_W       (PW)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_ctl   (res_ctl),
    .res_sum   (res_sum),
    .out_ch    (out_ch)
  );

endmodule

[hdl/pcal_front.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator front
// Holds the configuration registers, masks each frame and applies the range
// gate before pushing the frame into the queue.
// ----------------------------------------------------------------------------
module pcal_front #(
  parameter int PITCH_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  pcal_in_if.sink           in_ch,
  pcal_cfg_if.sink          cfg_ch,
  input  logic              q_full,
  output logic              push,
  output pcal_pkg::frame_t  frame,
  output pcal_pkg::cfg_t    cfg
);
  import pcal_pkg::*;

  localparam logic [15:0] PITCH_MASK = 16'((32'd1 << PITCH_W) - 32'd1);

  cfg_t        cfg_r;
  logic [15:0] pitch_m;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pitch     <= RST_MIN_PITCH;
      cfg_r.max_pitch     <= RST_MAX_PITCH;
      cfg_r.var_tol       <= RST_VAR_TOL;
      cfg_r.miss_limit    <= RST_MISS_LIMIT;
      cfg_r.center_tol    <= RST_CENTER_TOL;
      cfg_r.launch_target <= RST_LAUNCH_TGT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MIN_PITCH:  cfg_r.min_pitch     <= cfg_ch.data[15:0];
        CFG_MAX_PITCH:  cfg_r.max_pitch     <= cfg_ch.data[15:0];
        CFG_VAR_TOL:    cfg_r.var_tol       <= cfg_ch.data;
        CFG_MISS_LIMIT: cfg_r.miss_limit    <= cfg_ch.data[7:0];
        CFG_CENTER_TOL: cfg_r.center_tol    <= cfg_ch.data[15:0];
        CFG_LAUNCH_TGT: cfg_r.launch_target <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

  // A frame is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Mask to the pitch width and classify against the accepted range.
  assign pitch_m        = in_ch.pitch & PITCH_MASK;
  assign frame.pitch    = pitch_m;
  assign frame.in_range = (pitch_m >= cfg_r.min_pitch) && (pitch_m <= cfg_r.max_pitch);

endmodule

[hdl/pcal_queue.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator queue
// Short first-in first-out queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module pcal_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pcal_pkg::frame_t  wr_data,
  output logic              full,
  output logic              head_valid,
  output pcal_pkg::frame_t  head,
  input  logic              pop
);
  import pcal_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  frame_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hdl/pcal_back.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator back
// Runs the sliding window: the window memory, the running sum, the running
// spread N*sumsq - sum^2, the miss counter and the calibration phase.
// ----------------------------------------------------------------------------
module pcal_back #(
  parameter int WINDOW_LENGTH = 16,
  parameter int PITCH_W       = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  pcal_pkg::cfg_t                             cfg,
  input  logic                                       head_valid,
  input  pcal_pkg::frame_t                           head,
  output logic                                       pop,
  output logic                                       res_valid,
  input  logic                                       res_ready,
  output pcal_pkg::res_ctl_t                         res_ctl,
  output logic [PITCH_W + $clog2(WINDOW_LENGTH):0]   res_sum
);
  import pcal_pkg::*;

  localparam int LOGN = $clog2(WINDOW_LENGTH);
  localparam int AW   = LOGN;
  localparam int FW   = $clog2(WINDOW_LENGTH + 1);
  localparam int SW   = PITCH_W + LOGN;
  localparam int RW   = SW + 1;
  localparam int DW   = 2 * PITCH_W + 2 * LOGN;
  localparam int FXW  = PITCH_W + LOGN + 3;
  localparam int PRW  = PITCH_W + 1 + FXW;
  localparam int XW   = DW + 5;
  localparam int BW   = 32 + 2 * LOGN;
  localparam int CW   = (DW > BW) ? DW : BW;
  localparam int TW   = 17 + LOGN;
  localparam int NN   = WINDOW_LENGTH * WINDOW_LENGTH;

  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_LENGTH);
  localparam logic [FW-1:0] FILL_LAST = FW'(WINDOW_LENGTH - 1);
  localparam logic [AW-1:0] PTR_LAST  = AW'(WINDOW_LENGTH - 1);
  localparam logic [RW-1:0] HALF_N    = RW'(WINDOW_LENGTH / 2);

  // Window memory and its registered read port.
  logic [PITCH_W-1:0] win_mem [WINDOW_LENGTH];
  logic [PITCH_W-1:0] rd_data_r;

  // Window state.
  logic [1:0]     phase_r,  phase_nxt;
  logic [FW-1:0]  fill_r,   fill_nxt;
  logic [AW-1:0]  wp_r,     wp_nxt;
  logic [SW-1:0]  sum_r,    sum_nxt;
  logic [DW-1:0]  spread_r, spread_nxt;
  logic [7:0]     miss_r,   miss_nxt;

  // Bounds derived from configuration.
  logic [BW-1:0]  var_bound_r;
  logic [TW-1:0]  lo_bound_r;
  logic [TW-1:0]  hi_bound_r;
  logic           tgt_nz_r;
  logic [16:0]    tgt_inc;
  logic [16:0]    lo_base;
  logic [16:0]    hi_base;

  // Datapath.
  logic                   take;
  logic                   full;
  logic                   full_after;
  logic [PITCH_W-1:0]     pitch;
  logic [PITCH_W-1:0]     old;
  logic signed [PITCH_W:0] diff;
  logic [PITCH_W:0]       psum;
  logic [FXW-1:0]         n_psum;
  logic signed [FXW-1:0]  fx;
  logic signed [PRW-1:0]  prod;
  logic signed [XW-1:0]   spread_sum;
  logic [DW-1:0]          spread_upd;
  logic [SW-1:0]          sum_upd;
  logic [RW-1:0]          rsum;
  logic                   var_ok;
  logic                   near;
  logic [7:0]             miss_inc;
  logic                   we;
  logic                   clear;
  logic                   found;
  logic [1:0]             cap;

  assign take      = head_valid && res_ready;
  assign pop       = take;
  assign res_valid = head_valid;

  // Bounds: tolerance * N^2 for the spread, and the mean window around the launch target
  // scaled by N so it compares directly with the rounded sum.
  assign tgt_inc = {1'b0, cfg.launch_target} + 17'd1;
  assign lo_base = (tgt_inc > {1'b0, cfg.center_tol}) ?
                   (tgt_inc - {1'b0, cfg.center_tol}) : '0;
  assign hi_base = {1'b0, cfg.launch_target} + {1'b0, cfg.center_tol};

  always_ff @(posedge clk) begin
    var_bound_r <= BW'(cfg.var_tol) * BW'(NN);
    lo_bound_r  <= TW'(lo_base) * TW'(WINDOW_LENGTH);
    hi_bound_r  <= TW'(hi_base) * TW'(WINDOW_LENGTH);
    tgt_nz_r    <= (cfg.launch_target != '0);
  end

  // Incremental spread update: with d = new - old,
  // spread' = spread + d * (N*(new + old) - 2*sum - d).
  assign pitch      = head.pitch[PITCH_W-1:0];
  assign full       = (fill_r == FILL_FULL);
  assign full_after = full || (fill_r == FILL_LAST);
  assign old        = full ? rd_data_r : '0;
  assign diff       = $signed({1'b0, pitch}) - $signed({1'b0, old});
  assign psum       = {1'b0, pitch} + {1'b0, old};
  assign n_psum     = FXW'(psum) * FXW'(WINDOW_LENGTH);
  assign fx         = $signed(n_psum) - $signed(FXW'({sum_r, 1'b0})) - FXW'(diff);
  assign prod       = diff * fx;
  assign spread_sum = $signed(XW'(spread_r)) + XW'(prod);
  assign spread_upd = spread_sum[DW-1:0];
  assign sum_upd    = sum_r + SW'(pitch) - SW'(old);
  assign rsum       = RW'(sum_upd) + HALF_N;

  // Stability test and the distance test against the launch target.
  assign var_ok   = CW'(spread_upd) < CW'(var_bound_r);
  assign near     = tgt_nz_r && (TW'(rsum) >= lo_bound_r) && (TW'(rsum) < hi_bound_r);
  assign miss_inc = (miss_r == 8'hFF) ? miss_r : miss_r + 8'd1;

  // Next state for one frame.
  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    wp_nxt     = wp_r;
    sum_nxt    = sum_r;
    spread_nxt = spread_r;
    miss_nxt   = miss_r;
    we         = 1'b0;
    clear      = 1'b0;
    found      = 1'b0;
    cap        = CAP_NONE;
    if (take && (phase_r != PH_COUNTDOWN)) begin
      if (head.in_range) begin
        we         = 1'b1;
        miss_nxt   = '0;
        fill_nxt   = full ? fill_r : fill_r + FW'(1);
        wp_nxt     = (wp_r == PTR_LAST) ? '0 : wp_r + AW'(1);
        sum_nxt    = sum_upd;
        spread_nxt = spread_upd;
        if (full_after && var_ok) begin
          found = 1'b1;
          unique case (phase_r)
            PH_HIGH: begin
              cap       = CAP_HIGH;
              phase_nxt = PH_LOW;
              clear     = 1'b1;
            end
            PH_LOW: begin
              cap       = CAP_LOW;
              phase_nxt = PH_CENTER;
              clear     = 1'b1;
            end
            PH_CENTER: begin
              if (near) begin
                phase_nxt = PH_COUNTDOWN;
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        miss_nxt = miss_inc;
        if (miss_inc > cfg.miss_limit) begin
          clear = 1'b1;
        end
      end
      if (clear) begin
        fill_nxt   = '0;
        wp_nxt     = '0;
        sum_nxt    = '0;
        spread_nxt = '0;
        miss_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HIGH;
      fill_r   <= '0;
      wp_r     <= '0;
      sum_r    <= '0;
      spread_r <= '0;
      miss_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      wp_r     <= wp_nxt;
      sum_r    <= sum_nxt;
      spread_r <= spread_nxt;
      miss_r   <= miss_nxt;
    end
  end

  // The read port fetches the entry the next frame will overwrite.
  always_ff @(posedge clk) begin
    if (we) begin
      win_mem[wp_r] <= pitch;
    end
    rd_data_r <= win_mem[wp_nxt];
  end

  assign res_ctl.phase = phase_nxt;
  assign res_ctl.found = found;
  assign res_ctl.cap   = cap;
  assign res_sum       = rsum;

endmodule

[hdl/pcal_post.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator output stages
// Divides the rounded sum by the window length, captures the notes, forms
// the centre pitch and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module pcal_post #(
  parameter int WINDOW_LENGTH = 16,
  parameter int PITCH_W       = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      res_valid,
  output logic                                      res_ready,
  input  pcal_pkg::res_ctl_t                        res_ctl,
  input  logic [PITCH_W + $clog2(WINDOW_LENGTH):0]  res_sum,
  pcal_out_if.source                                out_ch
);
  import pcal_pkg::*;

  localparam int LOGN = $clog2(WINDOW_LENGTH);
  localparam int RW   = PITCH_W + LOGN + 1;
  localparam int KSH  = RW + LOGN;
  localparam int MW   = RW + 2;
  localparam int PW2  = RW + MW;
  // Reciprocal of N, exact for every sum of RW bits after the shift by KSH.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << KSH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  logic              s1_v_r;
  res_ctl_t          s1_ctl_r;
  logic [RW-1:0]     s1_sum_r;
  logic              s2_v_r;
  res_ctl_t          s2_ctl_r;
  logic [PW2-1:0]    s2_prod_r;
  logic              out_v_r;
  logic [1:0]        phase_r;
  logic              found_r;
  logic [15:0]       found_pitch_r;
  logic [15:0]       high_out_r;
  logic [15:0]       low_out_r;
  logic [15:0]       center_r;
  logic [15:0]       high_r, high_nxt;
  logic [15:0]       low_r,  low_nxt;
  logic [15:0]       mean;
  logic [16:0]       note_sum;
  logic              out_rdy;
  logic              s2_rdy;
  logic              s1_rdy;
  logic              adv_out;

  // Stage handshakes: a stage moves when it is empty or its successor moves.
  assign out_rdy   = !out_v_r || out_ch.ready;
  assign s2_rdy    = !s2_v_r || out_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign res_ready = s1_rdy;
  assign adv_out   = s2_v_r && out_rdy;

  // Mean from the registered product, then note capture and centre.
  assign mean     = 16'(s2_prod_r[KSH +: PITCH_W]);
  assign high_nxt = (s2_ctl_r.cap == CAP_HIGH) ? mean : high_r;
  assign low_nxt  = (s2_ctl_r.cap == CAP_LOW) ? mean : low_r;
  assign note_sum = {1'b0, high_nxt} + {1'b0, low_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      high_r  <= '0;
      low_r   <= '0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= res_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r;
      end
      if (adv_out) begin
        high_r <= high_nxt;
        low_r  <= low_nxt;
      end
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk) begin
    if (s1_rdy && res_valid) begin
      s1_ctl_r <= res_ctl;
      s1_sum_r <= res_sum;
    end
    if (s2_rdy && s1_v_r) begin
      s2_ctl_r  <= s1_ctl_r;
      s2_prod_r <= {{MW{1'b0}}, s1_sum_r} * {{RW{1'b0}}, RECIP};
    end
    if (adv_out) begin
      phase_r       <= s2_ctl_r.phase;
      found_r       <= s2_ctl_r.found;
      found_pitch_r <= s2_ctl_r.found ? mean : '0;
      high_out_r    <= high_nxt;
      low_out_r     <= low_nxt;
      center_r      <= note_sum[16:1];
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.phase        = phase_r;
  assign out_ch.found        = found_r;
  assign out_ch.found_pitch  = found_pitch_r;
  assign out_ch.high_pitch   = high_out_r;
  assign out_ch.low_pitch    = low_out_r;
  assign out_ch.center_pitch = center_r;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Pitch stability calibrator testbench
// Drives pitch frames through the input channel with random gaps, stalls the
// result channel at random, and checks every result beat against a local model
// of the sliding window, range gate and calibration phases or a typed table row.
// Register settings are changed between runs of frames while the block idles.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcal_pkg::*;

  localparam int WIN = 16;
  localparam int NUM_SETTINGS = 7;
  localparam int NUM_DIRECTED = 22;

  typedef struct packed {
    logic [1:0]  phase;
    logic        found;
    logic [15:0] found_pitch;
    logic [15:0] high_pitch;
    logic [15:0] low_pitch;
    logic [15:0] center_pitch;
  } calib_result_t;

  typedef struct packed {
    logic [15:0]   pitch;
    logic          typed;
    calib_result_t want;
  } stim_row_t;

  // Result of any frame that leaves the block untouched after reset.
  localparam calib_result_t IDLE_RESULT = '{PH_HIGH, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0};

  // Range gate edges with the reset settings, then a window of alternating
  // 1000 and 1001 whose mean sits exactly on a half and rounds up.
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{16'd0, 1'b1, IDLE_RESULT},
    '{16'hFFFF, 1'b1, IDLE_RESULT},
    '{16'd799, 1'b1, IDLE_RESULT},
    '{16'd32001, 1'b1, IDLE_RESULT},
    '{16'd800, 1'b1, IDLE_RESULT},
    '{16'd32000, 1'b1, IDLE_RESULT},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0},
    '{16'd1000, 1'b0, '0}, '{16'd1001, 1'b0, '0}
  };

  // Register settings, one per run of random frames. Field order: min, max,
  // variance tolerance, miss limit, centre tolerance, launch target.
  localparam cfg_t SETTING [NUM_SETTINGS] = '{
    '{16'd0, 16'hFFFF, 32'd4096, 8'd0, 16'd320, 16'd0},
    '{16'd800, 16'd32000, 32'd0, 8'd3, 16'hFFFF, 16'd0},
    '{16'hFFFF, 16'd0, 32'd4096, 8'd255, 16'd320, 16'd0},
    '{16'd100, 16'd60000, 32'hFFFF_FFFF, 8'd5, 16'd0, 16'd0},
    '{16'd800, 16'd32000, 32'd1000, 8'd10, 16'd0, 16'hFFFF},
    '{16'd800, 16'd32000, 32'd4096, 8'd10, 16'd320, 16'd0},
    '{16'd800, 16'd32000, 32'd4096, 8'd10, 16'd320, 16'd20000}
  };
  localparam int SETTING_FRAMES [NUM_SETTINGS] = '{230, 180, 250, 230, 230, 180, 180};

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
    CFG_MIN_PITCH, CFG_MAX_PITCH, CFG_VAR_TOL, CFG_MISS_LIMIT, CFG_CENTER_TOL, CFG_LAUNCH_TGT
  };

  logic clk = 1'b0;
  logic rst_n;

  pcal_in_if  in_bus ();
  pcal_out_if out_bus ();
  pcal_cfg_if cfg_bus ();

  pitch_stability_calibrator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .cfg_ch (cfg_bus),
    .out_ch (out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state: window contents, running sums, phase and captured notes.
  cfg_t              model_cfg;
  logic [15:0]       win_mem [WIN];
  int unsigned       fill_cnt;
  logic [3:0]        wr_ptr;
  longint unsigned   pitch_sum;
  longint unsigned   square_sum;
  int unsigned       miss_cnt;
  logic [1:0]        cal_phase;
  logic [15:0]       note_high;
  logic [15:0]       note_low;

  calib_result_t     pending_results [$];
  int unsigned       mismatches = 0;
  int                src_quiet = 0;
  int                sink_quiet = 0;

  // Current run of random frames.
  int                run_left = 0;
  int                run_base = 0;
  int                run_jit = 0;

  function automatic void clear_window();
    fill_cnt = 0;
    wr_ptr = '0;
    pitch_sum = 0;
    square_sum = 0;
    miss_cnt = 0;
  endfunction

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    unique case (idx)
      CFG_MIN_PITCH:  model_cfg.min_pitch = val[15:0];
      CFG_MAX_PITCH:  model_cfg.max_pitch = val[15:0];
      CFG_VAR_TOL:    model_cfg.var_tol = val;
      CFG_MISS_LIMIT: model_cfg.miss_limit = val[7:0];
      CFG_CENTER_TOL: model_cfg.center_tol = val[15:0];
      CFG_LAUNCH_TGT: model_cfg.launch_target = val[15:0];
      default: ;
    endcase
  endfunction

  // Advances the model by one frame and returns the result it produces.
  function automatic calib_result_t predict_frame(logic [15:0] pitch);
    calib_result_t   res;
    longint unsigned p64;
    longint unsigned old;
    longint unsigned spread;
    longint unsigned bound;
    longint unsigned mean;
    logic            found;
    int              offset;
    int              diff;
    p64 = pitch;
    found = 1'b0;
    mean = 0;
    if (cal_phase != PH_COUNTDOWN) begin
      if (pitch >= model_cfg.min_pitch && pitch <= model_cfg.max_pitch) begin
        miss_cnt = 0;
        if (fill_cnt >= WIN) begin
          old = win_mem[wr_ptr];
          pitch_sum -= old;
          square_sum -= old * old;
        end else begin
          fill_cnt++;
        end
        win_mem[wr_ptr] = pitch;
        pitch_sum += p64;
        square_sum += p64 * p64;
        wr_ptr = wr_ptr + 4'd1;
        if (fill_cnt == WIN) begin
          spread = WIN * square_sum - pitch_sum * pitch_sum;
          bound = 64'(model_cfg.var_tol) * WIN * WIN;
          if (spread < bound) begin
            found = 1'b1;
            mean = (pitch_sum + WIN / 2) / WIN;
          end
        end
      end else begin
        if (miss_cnt < 255) miss_cnt++;
        if (miss_cnt > model_cfg.miss_limit) clear_window();
      end

      // A stable pitch captures a note or, in the centre phase, may launch.
      if (found) begin
        unique case (cal_phase)
          PH_HIGH: begin
            note_high = mean[15:0];
            cal_phase = PH_LOW;
            clear_window();
          end
          PH_LOW: begin
            note_low = mean[15:0];
            cal_phase = PH_CENTER;
            clear_window();
          end
          default: begin
            if (model_cfg.launch_target != 16'd0) begin
              offset = int'(mean) - int'(model_cfg.launch_target);
              if (offset < 0) offset = -offset;
              if (offset < int'(model_cfg.center_tol)) cal_phase = PH_COUNTDOWN;
            end
          end
        endcase
      end
    end

    diff = int'(note_high) - int'(note_low);
    res.phase = cal_phase;
    res.found = found;
    res.found_pitch = found ? mean[15:0] : 16'd0;
    res.high_pitch = note_high;
    res.low_pitch = note_low;
    res.center_pitch = 16'(int'(note_low) + (diff >>> 1));
    return res;
  endfunction

  // Gap before the next beat; now and then a stretch of back-to-back beats.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(20, 80);
    return $urandom_range(0, 15);
  endfunction

  // Mostly steady runs with small jitter, some with wide spread, some noise.
  function automatic logic [15:0] next_pitch();
    int v;
    int pick;
    if (run_left == 0) begin
      pick = $urandom_range(0, 19);
      run_left = $urandom_range(16, 40);
      if (model_cfg.launch_target != 16'd0 && pick < 6)
        run_base = int'(model_cfg.launch_target) + $urandom_range(0, 800) - 400;
      else if (model_cfg.min_pitch <= model_cfg.max_pitch)
        run_base = $urandom_range(model_cfg.max_pitch, model_cfg.min_pitch);
      else
        run_base = $urandom_range(0, 65535);
      if (pick < 14) begin
        run_jit = $urandom_range(0, 40);
      end else if (pick < 17) begin
        run_jit = $urandom_range(100, 3000);
      end else begin
        run_jit = -1;
        run_left = $urandom_range(1, 24);
      end
    end
    run_left--;
    if (run_jit < 0) begin
      if ($urandom_range(0, 1) == 0) v = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      else v = $urandom_range(0, 65535);
    end else begin
      v = run_base + $urandom_range(0, 2 * run_jit) - run_jit;
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endfunction

  // Sends one frame and records what it should produce.
  task automatic send_frame(logic [15:0] pitch, logic typed, calib_result_t typed_res);
    int            gap;
    calib_result_t predicted;
    calib_result_t expected;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.pitch <= pitch;
    do @(posedge clk); while (!in_bus.ready);
    predicted = predict_frame(pitch);
    expected = typed ? typed_res : predicted;
    pending_results.insert(pending_results.size(), expected);
  endtask

  // Stops the input and waits until every result beat has come back.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all six registers in back-to-back beats.
  task automatic load_settings(cfg_t s);
    logic [CFG_DATA_W-1:0] val;
    foreach (REG_ORDER[i]) begin
      unique case (REG_ORDER[i])
        CFG_MIN_PITCH:  val = 32'(s.min_pitch);
        CFG_MAX_PITCH:  val = 32'(s.max_pitch);
        CFG_VAR_TOL:    val = s.var_tol;
        CFG_MISS_LIMIT: val = 32'(s.miss_limit);
        CFG_CENTER_TOL: val = 32'(s.center_tol);
        default:        val = 32'(s.launch_target);
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= REG_ORDER[i];
      cfg_bus.data <= val;
      do @(posedge clk); while (!cfg_bus.ready);
      set_register(REG_ORDER[i], val);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Stimulus: reset, directed table, then runs of random frames per setting.
  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.pitch <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    model_cfg = '{RST_MIN_PITCH, RST_MAX_PITCH, RST_VAR_TOL, RST_MISS_LIMIT,
                  RST_CENTER_TOL, RST_LAUNCH_TGT};
    clear_window();
    cal_phase = PH_HIGH;
    note_high = '0;
    note_low = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_frame(DIRECTED[i].pitch, DIRECTED[i].typed, DIRECTED[i].want);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      load_settings(SETTING[s]);
      repeat (SETTING_FRAMES[s]) send_frame(next_pitch(), 1'b0, '0);
    end
    wait_idle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0)
      $display("[pitch_stability_calibrator] OK");
    else
      $display("[pitch_stability_calibrator] ERROR");
    $finish;
  end

  // Result side: random stalls, each beat checked against the oldest expectation.
  initial begin
    int            gap;
    calib_result_t got;
    calib_result_t want;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(sink_quiet);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got = '{out_bus.phase, out_bus.found, out_bus.found_pitch, out_bus.high_pitch,
              out_bus.low_pitch, out_bus.center_pitch};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, phase", 0, got.phase);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.phase !== want.phase) report_mismatch("phase", want.phase, got.phase);
        if (got.found !== want.found) report_mismatch("found", want.found, got.found);
        if (got.found_pitch !== want.found_pitch)
          report_mismatch("found_pitch", want.found_pitch, got.found_pitch);
        if (got.high_pitch !== want.high_pitch)
          report_mismatch("high_pitch", want.high_pitch, got.high_pitch);
        if (got.low_pitch !== want.low_pitch)
          report_mismatch("low_pitch", want.low_pitch, got.low_pitch);
        if (got.center_pitch !== want.center_pitch)
          report_mismatch("center_pitch", want.center_pitch, got.center_pitch);
      end
    end
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("[pitch_stability_calibrator] ERROR");
    $finish;
  end

endmodule
